// ----- sv/shrs_pkg.sv -----
package shrs_pkg;

    // item operations
    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    // selection policies
    localparam logic POLICY_SJF  = 1'b0;
    localparam logic POLICY_HRRN = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DISPATCH = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd1;

    localparam logic [8:0] ALPHA_ONE   = 9'd256;
    localparam logic [8:0] ALPHA_RESET = 9'd128;

    // shared multiplier: wait or alpha (32) times estimate or burst (24)
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic        op;
        logic [7:0]  proc_id;
        logic [15:0] last_burst;
        logic [23:0] prior_estimate;
        logic        needs_estimate;
        logic [31:0] now_ms;
        logic [3:0]  free_slots;
    } t_sched_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] dispatched_id;
        logic [4:0] ready_count;
    } t_sched_out;

    typedef struct packed {
        logic [7:0]  id;
        logic [23:0] estimate;
        logic [31:0] arrival;
    } t_entry;

endpackage

// ----- sv/sjf_hrrn_ready_scheduler_unit.sv -----
// Channel   Ports                               Transfer
// item in   start, busy, i_item (t_sched_in)    start high while busy low
// result    o_valid, o_result (t_sched_out)     o_valid high for one cycle
// config    i_cfg_we, i_cfg_idx, i_cfg_data     i_cfg_we high, no wait
//
// One item at a time; busy holds until its last step, the result shows in the cycle after
// it and the receiver cannot stall it. A full table or a schedule that dispatches nothing
// answers straight from idle. An insert first runs the estimate update when asked, then
// searches the slots in order for the first free one. A schedule evaluates all READY_DEPTH
// slots (in HRRN with extra product and compare steps per occupied slot after the first when
// it and the best so far have nonzero estimates), then an age-rank sweep, skipped when the
// youngest entry leaves. Reset is synchronous and empties the table at once.
module sjf_hrrn_ready_scheduler_unit
    import shrs_pkg::*;
#(
    parameter int READY_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_sched_in             i_item,
    output logic                  o_valid,
    output t_sched_out            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(READY_DEPTH);
    localparam int CW = $clog2(READY_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(READY_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(READY_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EST1,
        S_EST2,
        S_EST3,
        S_FIND,
        S_EVAL,
        S_MUL2,
        S_CMP,
        S_DEL,
        S_SWEEP
    } t_state;

    t_state            r_state, n_state;
    t_sched_in         r_item, n_item;
    logic [IW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_count, n_count;
    logic [23:0]       r_est, n_est;
    logic [31:0]       r_acc, n_acc;
    logic [MUL_P_W-1:0] r_lc, n_lc;
    logic              r_have, n_have;
    logic [IW-1:0]     r_bidx, n_bidx;
    logic [23:0]       r_best_est, n_best_est;
    logic [31:0]       r_best_wait, n_best_wait;
    logic [IW-1:0]     r_best_ord, n_best_ord;
    logic [7:0]        r_best_id, n_best_id;
    logic              r_res_valid, n_res_valid;
    t_sched_out        r_result, n_result;

    logic              r_policy;
    logic [8:0]        r_alpha;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    logic              ent_we;
    t_entry            ent_wdata;
    logic              ord_we;
    logic [IW-1:0]     ord_addr;
    logic [IW-1:0]     ord_wdata;
    logic              clr_en;
    t_entry            ent_rd;
    logic [IW-1:0]     ord_rd;
    logic [READY_DEPTH-1:0] valid_vec;

    logic [8:0]        alpha_sat;
    logic [31:0]       cand_wait;
    logic [31:0]       est_sum;
    logic              older;
    logic              above;
    logic              accept;

    assign accept    = start && (r_state == S_IDLE);
    assign alpha_sat = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign cand_wait = r_item.now_ms - ent_rd.arrival;
    assign est_sum   = r_acc + mul_p[31:0];
    assign older     = ord_rd < r_best_ord;

    shrs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    shrs_table #(
        .DEPTH (READY_DEPTH),
        .IW    (IW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ent_we    (ent_we),
        .i_ent_addr  (r_idx),
        .i_ent_wdata (ent_wdata),
        .i_ord_we    (ord_we),
        .i_ord_addr  (ord_addr),
        .i_ord_wdata (ord_wdata),
        .i_clr_en    (clr_en),
        .i_clr_addr  (r_bidx),
        .i_raddr     (n_idx),
        .o_ent_rdata (ent_rd),
        .o_ord_rdata (ord_rd),
        .o_valid     (valid_vec)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_EST1: begin
                mul_a = MUL_A_W'(alpha_sat);
                mul_b = {r_item.last_burst, 8'h00};
            end
            S_EST2: begin
                mul_a = MUL_A_W'(ALPHA_ONE - alpha_sat);
                mul_b = r_item.prior_estimate;
            end
            S_EVAL: begin
                mul_a = cand_wait;
                mul_b = r_best_est;
            end
            S_MUL2: begin
                mul_a = r_best_wait;
                mul_b = ent_rd.estimate;
            end
            default: begin
            end
        endcase
    end

    // rank of the candidate slot against the best so far
    always_comb begin
        above = older;
        if (r_state == S_CMP) begin
            if (r_lc != mul_p) begin
                above = r_lc > mul_p;
            end
        end else if (r_policy == POLICY_SJF) begin
            if (ent_rd.estimate != r_best_est) begin
                above = ent_rd.estimate < r_best_est;
            end
        end else if ((ent_rd.estimate == 24'd0) != (r_best_est == 24'd0)) begin
            above = ent_rd.estimate == 24'd0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_idx       = r_idx;
        n_count     = r_count;
        n_est       = r_est;
        n_acc       = r_acc;
        n_lc        = r_lc;
        n_have      = r_have;
        n_bidx      = r_bidx;
        n_best_est  = r_best_est;
        n_best_wait = r_best_wait;
        n_best_ord  = r_best_ord;
        n_best_id   = r_best_id;
        n_res_valid = 1'b0;
        n_result    = r_result;
        ent_we      = 1'b0;
        ent_wdata   = '{id: r_item.proc_id, estimate: r_est, arrival: r_item.now_ms};
        ord_we      = 1'b0;
        ord_addr    = r_idx;
        ord_wdata   = ord_rd - IW'(1);
        clr_en      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item = i_item;
                    n_idx  = '0;
                    if (i_item.op == OP_INSERT) begin
                        n_est = i_item.prior_estimate;
                        if (r_count == FULL_CNT) begin
                            n_res_valid = 1'b1;
                            n_result    = '{ST_FULL, 8'd0, 5'(r_count)};
                        end else if (i_item.needs_estimate) begin
                            n_state = S_EST1;
                        end else begin
                            n_state = S_FIND;
                        end
                    end else if (i_item.free_slots == 4'd0 || r_count == '0) begin
                        n_res_valid = 1'b1;
                        n_result    = '{ST_NONE, 8'd0, 5'(r_count)};
                    end else begin
                        n_have  = 1'b0;
                        n_state = S_EVAL;
                    end
                end
            end
            S_EST1: begin
                n_state = S_EST2;
            end
            S_EST2: begin
                n_acc   = mul_p[31:0];
                n_state = S_EST3;
            end
            S_EST3: begin
                n_est   = est_sum[31:8];
                n_state = S_FIND;
            end
            S_FIND: begin
                if (!valid_vec[r_idx]) begin
                    ent_we      = 1'b1;
                    ord_we      = 1'b1;
                    ord_wdata   = IW'(r_count);
                    n_count     = r_count + CW'(1);
                    n_res_valid = 1'b1;
                    n_result    = '{ST_INSERTED, 8'd0, 5'(n_count)};
                    n_state     = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_EVAL, S_CMP: begin
                if (r_state == S_EVAL && valid_vec[r_idx] && r_have &&
                    r_policy == POLICY_HRRN && ent_rd.estimate != 24'd0 &&
                    r_best_est != 24'd0) begin
                    // product of candidate wait and best estimate is in flight
                    n_state = S_MUL2;
                end else begin
                    if (valid_vec[r_idx] && (!r_have || above)) begin
                        n_have      = 1'b1;
                        n_bidx      = r_idx;
                        n_best_est  = ent_rd.estimate;
                        n_best_wait = cand_wait;
                        n_best_ord  = ord_rd;
                        n_best_id   = ent_rd.id;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_DEL;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_EVAL;
                    end
                end
            end
            S_MUL2: begin
                n_lc    = mul_p;
                n_state = S_CMP;
            end
            S_DEL: begin
                clr_en  = 1'b1;
                n_count = r_count - CW'(1);
                n_idx   = '0;
                if (r_best_ord == IW'(n_count)) begin
                    n_res_valid = 1'b1;
                    n_result    = '{ST_DISPATCH, r_best_id, 5'(n_count)};
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                // close the age-rank gap left by the removed entry
                if (valid_vec[r_idx] && ord_rd > r_best_ord) begin
                    ord_we = 1'b1;
                end
                if (r_idx == LAST_IDX) begin
                    n_res_valid = 1'b1;
                    n_result    = '{ST_DISPATCH, r_best_id, 5'(r_count)};
                    n_state     = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_have      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_have      <= n_have;
            r_res_valid <= n_res_valid;
        end
        r_item      <= n_item;
        r_idx       <= n_idx;
        r_est       <= n_est;
        r_acc       <= n_acc;
        r_lc        <= n_lc;
        r_bidx      <= n_bidx;
        r_best_est  <= n_best_est;
        r_best_wait <= n_best_wait;
        r_best_ord  <= n_best_ord;
        r_best_id   <= n_best_id;
        r_result    <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_SJF;
            r_alpha  <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLICY: r_policy <= i_cfg_data[0];
                CFG_ALPHA:  r_alpha  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_res_valid;
    assign o_result = r_result;

endmodule

// ----- sv/shrs_mul.sv -----
module shrs_mul
    import shrs_pkg::*;
(
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- sv/shrs_table.sv -----
module shrs_table
    import shrs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ent_we,
    input  logic [IW-1:0]    i_ent_addr,
    input  t_entry           i_ent_wdata,
    input  logic             i_ord_we,
    input  logic [IW-1:0]    i_ord_addr,
    input  logic [IW-1:0]    i_ord_wdata,
    input  logic             i_clr_en,
    input  logic [IW-1:0]    i_clr_addr,
    input  logic [IW-1:0]    i_raddr,
    output t_entry           o_ent_rdata,
    output logic [IW-1:0]    o_ord_rdata,
    output logic [DEPTH-1:0] o_valid
);

    t_entry           mem_ent [DEPTH];
    logic [IW-1:0]    mem_ord [DEPTH];
    t_entry           r_ent_rdata;
    logic [IW-1:0]    r_ord_rdata;
    logic [DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            mem_ent[i_ent_addr] <= i_ent_wdata;
        end
        r_ent_rdata <= mem_ent[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ord_we) begin
            mem_ord[i_ord_addr] <= i_ord_wdata;
        end
        r_ord_rdata <= mem_ord[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_ent_we) begin
                r_valid[i_ent_addr] <= 1'b1;
            end
            if (i_clr_en) begin
                r_valid[i_clr_addr] <= 1'b0;
            end
        end
    end

    assign o_ent_rdata = r_ent_rdata;
    assign o_ord_rdata = r_ord_rdata;
    assign o_valid     = r_valid;

endmodule

// ----- test/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import shrs_pkg::*;

    localparam int TABLE_DEPTH = 16;

    // the two indexes that the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_sched_in             item;
    } t_sched_cmd;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_sched_in             item = '0;
    logic                  res_valid;
    t_sched_out            res;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sjf_hrrn_ready_scheduler_unit #(
        .READY_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (item),
        .o_valid   (res_valid),
        .o_result  (res),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // predicted ready table and registers
    logic                  m_policy = POLICY_SJF;
    logic [8:0]            m_alpha = ALPHA_RESET;
    bit                    slot_used [TABLE_DEPTH];
    logic [7:0]            slot_id   [TABLE_DEPTH];
    logic [23:0]           slot_est  [TABLE_DEPTH];
    logic [31:0]           slot_arr  [TABLE_DEPTH];
    int unsigned           slot_age  [TABLE_DEPTH];

    t_sched_cmd            cmd_q[$];
    t_sched_out            outcome_q[$];
    bit                    xfer_done = 1'b0;
    int                    gap_left = 0;
    logic [31:0]           clock_ms = 32'd1000;

    int                    n_errors = 0;
    int                    n_checked = 0;
    int                    n_status [4] = '{0, 0, 0, 0};
    int                    n_cfg = 0;

    function automatic logic [23:0] blend_estimate(logic [15:0] burst, logic [23:0] prior);
        logic [63:0] w;
        logic [63:0] acc;
        w = (m_alpha > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(m_alpha);
        acc = w * (64'(burst) << 8) + (64'd256 - w) * 64'(prior);
        return acc[31:8];
    endfunction

    // true when slot c beats slot b at instant now
    function automatic bit outranks(int c, int b, logic [31:0] now);
        logic [31:0] wc;
        logic [31:0] wb;
        logic [63:0] lc;
        logic [63:0] lb;
        if (m_policy == POLICY_SJF) begin
            if (slot_est[c] != slot_est[b]) return slot_est[c] < slot_est[b];
        end else if (slot_est[c] == '0 || slot_est[b] == '0) begin
            if ((slot_est[c] == '0) != (slot_est[b] == '0)) return slot_est[c] == '0;
        end else begin
            wc = now - slot_arr[c];
            wb = now - slot_arr[b];
            lc = 64'(wc) * 64'(slot_est[b]);
            lb = 64'(wb) * 64'(slot_est[c]);
            if (lc != lb) return lc > lb;
        end
        return slot_age[c] < slot_age[b];
    endfunction

    function automatic t_sched_out ready_table_step(t_sched_in it);
        t_sched_out  r;
        int          slot;
        int          best;
        int unsigned n;
        int unsigned gone;
        r = '0;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) if (slot_used[i]) n++;
        if (it.op == OP_INSERT) begin
            slot = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) if (!slot_used[i] && slot < 0) slot = i;
            if (slot < 0) begin
                r.status = ST_FULL;
            end else begin
                slot_used[slot] = 1'b1;
                slot_id[slot] = it.proc_id;
                slot_est[slot] = it.needs_estimate ?
                    blend_estimate(it.last_burst, it.prior_estimate) : it.prior_estimate;
                slot_arr[slot] = it.now_ms;
                slot_age[slot] = n;
                n++;
                r.status = ST_INSERTED;
            end
        end else if (it.free_slots == '0 || n == 0) begin
            r.status = ST_NONE;
        end else begin
            best = -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (slot_used[i] && (best < 0 || outranks(i, best, it.now_ms))) best = i;
            gone = slot_age[best];
            r.dispatched_id = slot_id[best];
            slot_used[best] = 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (slot_used[i] && slot_age[i] > gone) slot_age[i]--;
            n--;
            r.status = ST_DISPATCH;
        end
        r.ready_count = n[4:0];
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        n_errors++;
        if (n_errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // monitor: check results, then record a new transfer or register write
    always @(posedge clk) begin : watch
        t_sched_out want;
        if (rst_n) begin
            if (res_valid) begin
                if (outcome_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected result status %0d id %0d count %0d",
                                            res.status, res.dispatched_id, res.ready_count));
                end else begin
                    want = outcome_q.pop_front();
                    n_checked++;
                    n_status[want.status]++;
                    if (res.status !== want.status)
                        note_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                                n_checked, want.status, res.status));
                    if (res.dispatched_id !== want.dispatched_id)
                        note_mismatch($sformatf("result %0d dispatched_id: expected %0d, got %0d",
                                                n_checked, want.dispatched_id,
                                                res.dispatched_id));
                    if (res.ready_count !== want.ready_count)
                        note_mismatch($sformatf("result %0d ready_count: expected %0d, got %0d",
                                                n_checked, want.ready_count, res.ready_count));
                end
            end
            if (start && !busy) begin
                outcome_q.push_back(ready_table_step(item));
                xfer_done = 1'b1;
            end
            if (cfg_we) begin
                n_cfg++;
                if (cfg_idx == CFG_POLICY) m_policy = cfg_data[0];
                else if (cfg_idx == CFG_ALPHA) m_alpha = cfg_data;
            end
        end
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // driver: hold start until the transfer, then take the next command
    always @(negedge clk) begin : drive
        logic                  nx_start;
        t_sched_in             nx_item;
        logic                  nx_we;
        logic [CFG_IDX_W-1:0]  nx_idx;
        logic [CFG_DATA_W-1:0] nx_data;
        t_sched_cmd            c;
        nx_start = start;
        nx_item = item;
        nx_we = 1'b0;
        nx_idx = cfg_idx;
        nx_data = cfg_data;
        if (rst_n && !(start && !xfer_done)) begin
            nx_start = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_q.size() > 0) begin
                if (!cmd_q[0].is_cfg) begin
                    c = cmd_q.pop_front();
                    nx_start = 1'b1;
                    nx_item = c.item;
                    gap_left = draw_gap();
                end else if (outcome_q.size() == 0) begin
                    // registers change only with the table idle
                    c = cmd_q.pop_front();
                    nx_we = 1'b1;
                    nx_idx = c.idx;
                    nx_data = c.data;
                end
            end
        end
        xfer_done = 1'b0;
        start <= nx_start;
        item <= nx_item;
        cfg_we <= nx_we;
        cfg_idx <= nx_idx;
        cfg_data <= nx_data;
    end

    task automatic push_item(t_sched_in it);
        t_sched_cmd c;
        c.is_cfg = 1'b0;
        c.idx = '0;
        c.data = '0;
        c.item = it;
        cmd_q.push_back(c);
    endtask

    task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_sched_cmd c;
        c.is_cfg = 1'b1;
        c.idx = idx;
        c.data = data;
        c.item = '0;
        cmd_q.push_back(c);
    endtask

    function automatic t_sched_in make_insert(logic [7:0] id, logic [15:0] burst,
                                              logic [23:0] prior, logic needs,
                                              logic [31:0] now);
        t_sched_in it;
        it = '0;
        it.op = OP_INSERT;
        it.proc_id = id;
        it.last_burst = burst;
        it.prior_estimate = prior;
        it.needs_estimate = needs;
        it.now_ms = now;
        it.free_slots = 4'($urandom());
        return it;
    endfunction

    function automatic t_sched_in make_schedule(logic [31:0] now, logic [3:0] slots);
        t_sched_in it;
        it = t_sched_in'({$urandom(), $urandom(), $urandom()});
        it.op = OP_SCHEDULE;
        it.now_ms = now;
        it.free_slots = slots;
        return it;
    endfunction

    function automatic t_sched_in random_item(int insert_pct);
        t_sched_in   it;
        logic [23:0] prior;
        logic [15:0] burst;
        case ($urandom_range(0, 19))
            0: clock_ms = $urandom();
            1: clock_ms = clock_ms - $urandom_range(0, 500);
            2, 3: ;
            default: clock_ms = clock_ms + $urandom_range(1, 2000);
        endcase
        case ($urandom_range(0, 9))
            0: prior = '0;
            1: prior = '1;
            2, 3, 4: prior = 24'($urandom_range(1, 4)) << 8;
            default: prior = 24'($urandom());
        endcase
        case ($urandom_range(0, 7))
            0: burst = '0;
            1: burst = '1;
            default: burst = 16'($urandom());
        endcase
        if ($urandom_range(0, 99) < insert_pct) begin
            it = make_insert(8'($urandom()), burst, prior, 1'($urandom()), clock_ms);
        end else begin
            it = make_schedule(clock_ms,
                               ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(1, 15)));
        end
        return it;
    endfunction

    task automatic random_phase(int count, int insert_pct);
        for (int k = 0; k < count; k++) push_item(random_item(insert_pct));
    endtask

    initial begin : stimulus
        int i;
        // directed: empty table, fill to full, overflow, idle and real dispatches
        push_item(make_schedule(32'd0, 4'd15));
        for (i = 0; i < TABLE_DEPTH; i++) begin
            push_item(make_insert(8'(i * 17),
                                  (i & 2) ? 16'hFFFF : 16'h0000,
                                  (i % 4 == 0) ? 24'h000000 :
                                  (i % 4 == 1) ? 24'hFFFFFF : 24'h000300,
                                  (i % 3 == 0),
                                  (i == TABLE_DEPTH - 1) ? 32'hFFFF_FFFF : 32'(i * 100)));
        end
        push_item(make_insert(8'hAA, 16'h1234, 24'h000100, 1'b1, 32'hFFFF_FFFF));
        push_item(make_schedule(32'd2000, 4'd0));
        push_item(make_schedule(32'd2000, 4'd15));
        push_item(make_schedule(32'd2100, 4'd1));
        push_item(make_schedule(32'd2200, 4'd8));
        // response ratio with saturated alpha, clock behind most arrivals
        push_cfg(CFG_POLICY, {8'h00, POLICY_HRRN});
        push_cfg(CFG_ALPHA, 9'h1FF);
        push_item(make_insert(8'h5A, 16'hFFFF, 24'h000001, 1'b1, 32'd50));
        push_item(make_schedule(32'd5, 4'd3));
        push_item(make_schedule(32'd5, 4'd15));
        push_item(make_schedule(32'd900, 4'd2));

        // random phases over several register settings
        push_cfg(CFG_POLICY, {8'($urandom()), POLICY_SJF});
        push_cfg(CFG_ALPHA, 9'd0);
        random_phase(100, 60);
        push_cfg(CFG_ALPHA, ALPHA_ONE);
        random_phase(100, 70);
        push_cfg(CFG_POLICY, {8'($urandom()), POLICY_HRRN});
        push_cfg(CFG_SPARE_LO, 9'($urandom()));
        random_phase(100, 55);
        push_cfg(CFG_ALPHA, 9'h1FF);
        random_phase(100, 45);
        push_cfg(CFG_ALPHA, 9'd1);
        push_cfg(CFG_SPARE_HI, 9'h1FF);
        random_phase(100, 65);
        push_cfg(CFG_POLICY, {8'h00, POLICY_SJF});
        push_cfg(CFG_ALPHA, 9'd255);
        random_phase(100, 50);
        for (i = 0; i < 2; i++) begin
            push_cfg(CFG_POLICY, 9'($urandom()));
            push_cfg(CFG_ALPHA, 9'($urandom_range(0, 511)));
            random_phase(100, 40 + 25 * i);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() != 0 || start || outcome_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Checked %0d results: %0d inserts, %0d rejected on a full table,",
                 n_checked, n_status[ST_INSERTED], n_status[ST_FULL]);
        $display("%0d dispatches, %0d schedules with nothing taken, %0d register writes",
                 n_status[ST_DISPATCH], n_status[ST_NONE], n_cfg);
        if (n_errors == 0 && outcome_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
